@@ rtl/drz_pkg.sv @@
// Shared types and constants for the dual-stick radial dead-zone block.
// No dependencies; every other file but drz_if imports this package.
package drz_pkg;

  // Fixed field widths
  localparam int PKT_W      = 32;
  localparam int AXIS_W     = 16;
  localparam int DZ_W       = 15;
  localparam int FS_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int QUO_W      = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'b1;

  // Register reset values
  localparam logic [DZ_W-1:0] DZ_RESET = 15'd3277;
  localparam logic [FS_W-1:0] FS_RESET = 16'd32767;

  // Largest Q1.15 magnitude
  localparam logic [QUO_W-2:0] Q15_MAX = 15'h7FFF;

  // Classified report passed from the front end to the back end
  typedef struct packed {
    logic              hold;
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
  } drz_cmd_t;

  // Status and result of one stick lane
  typedef struct packed {
    logic              busy;
    logic [AXIS_W-1:0] x_out;
    logic [AXIS_W-1:0] y_out;
  } drz_lane_rsp_t;

  typedef enum logic [3:0] {
    STK_IDLE,
    STK_SQUARE,
    STK_CHECK,
    STK_ROOT,
    STK_PREP,
    STK_MUL,
    STK_NUM,
    STK_DIV,
    STK_FIN
  } stk_state_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

endpackage

@@ rtl/drz_if.sv @@
// Valid/ready channel interfaces for controller reports and stick results.
// Plain logic signals; no package dependency.
interface drz_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_number;
  logic [15:0] left_x_raw;
  logic [15:0] left_y_raw;
  logic [15:0] right_x_raw;
  logic [15:0] right_y_raw;

  modport source (output valid, packet_number, left_x_raw, left_y_raw,
                  right_x_raw, right_y_raw, input ready);
  modport sink (input valid, packet_number, left_x_raw, left_y_raw,
                right_x_raw, right_y_raw, output ready);
endinterface

interface drz_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_x_out;
  logic [15:0] left_y_out;
  logic [15:0] right_x_out;
  logic [15:0] right_y_out;
  logic        updated;

  modport source (output valid, left_x_out, left_y_out, right_x_out,
                  right_y_out, updated, input ready);
  modport sink (input valid, left_x_out, left_y_out, right_x_out,
                right_y_out, updated, output ready);
endinterface

@@ rtl/dual_stick_radial_deadzone_top.sv @@
// Dual thumb-stick radial dead zone with repeated-packet hold. For each
// report whose packet number differs from the previous one, the two stick
// lanes run side by side; each computes an AXIS_WIDTH+8-bit root in its
// one-bit-per-cycle square root and 16-bit quotients in its restoring
// divider (both axes divided together). A report with a repeated packet
// number returns the held axes once the back end is idle and the output
// slot is free. A two-entry queue lets new reports be accepted while a
// result waits on the output. The user must write configuration through
// cfg_we, cfg_index and cfg_data while the block is idle; it is not enforced.
// Depends on drz_pkg, drz_if, drz_fifo, drz_front, drz_back.
module dual_stick_radial_deadzone_top #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  drz_in_if.sink                          report,
  drz_out_if.source                       result,
  input  logic                            cfg_we,
  input  logic [drz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drz_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import drz_pkg::*;

  logic [DZ_W-1:0] deadzone_radius;
  logic [FS_W-1:0] full_scale_radius;
  logic            push, full, pop, not_empty;
  drz_cmd_t        push_cmd, pop_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_radius   <= DZ_RESET;
      full_scale_radius <= FS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEADZONE:   deadzone_radius   <= cfg_data[DZ_W-1:0];
        CFG_FULL_SCALE: full_scale_radius <= cfg_data[FS_W-1:0];
        default:        deadzone_radius   <= deadzone_radius;
      endcase
    end
  end

  drz_front u_front (
    .clk(clk), .rst(rst), .report(report), .full(full),
    .push(push), .push_cmd(push_cmd)
  );

  drz_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .full(full),
    .pop(pop), .pop_cmd(pop_cmd), .not_empty(not_empty)
  );

  drz_back #(.AXIS_WIDTH(AXIS_WIDTH)) u_back (
    .clk(clk), .rst(rst), .cmd(pop_cmd), .cmd_valid(not_empty), .pop(pop),
    .dz(deadzone_radius), .fs(full_scale_radius), .result(result)
  );

endmodule

@@ rtl/drz_fifo.sv @@
// Two-entry queue of classified reports between front and back end.
// Depends on drz_pkg for the command type.
module drz_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  drz_pkg::drz_cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output drz_pkg::drz_cmd_t pop_cmd,
  output logic             not_empty
);
  import drz_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  drz_cmd_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/drz_front.sv @@
// Front end: accepts reports, compares the packet number with the last one
// and queues a hold or compute command. Depends on drz_pkg and drz_in_if.
module drz_front (
  input  logic              clk,
  input  logic              rst,
  drz_in_if.sink            report,
  input  logic              full,
  output logic              push,
  output drz_pkg::drz_cmd_t push_cmd
);
  import drz_pkg::*;

  logic [PKT_W-1:0] last_packet;

  assign report.ready = !full;
  assign push         = report.valid && !full;

  // Classify the report
  always_comb begin
    push_cmd.hold    = (report.packet_number == last_packet);
    push_cmd.left_x  = report.left_x_raw;
    push_cmd.left_y  = report.left_y_raw;
    push_cmd.right_x = report.right_x_raw;
    push_cmd.right_y = report.right_y_raw;
  end

  // Track the last packet number on every transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      last_packet <= '0;
    end else if (push) begin
      last_packet <= report.packet_number;
    end
  end

endmodule

@@ rtl/drz_stick.sv @@
// One stick lane: dead-zone test, bit-serial square root of the length and
// two restoring dividers for the scaled axes. Depends on drz_pkg.
module drz_stick #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [drz_pkg::AXIS_W-1:0]  x_raw,
  input  logic [drz_pkg::AXIS_W-1:0]  y_raw,
  input  logic [drz_pkg::DZ_W-1:0]    dz,
  input  logic [drz_pkg::FS_W-1:0]    fs,
  output drz_pkg::drz_lane_rsp_t      rsp
);
  import drz_pkg::*;

  localparam int AW    = AXIS_WIDTH;
  localparam int SQW   = 2 * AW;
  localparam int RW    = AW + 8;
  localparam int RADW  = 2 * RW;
  localparam int REMW  = RW + 4;
  localparam int DW    = RW + 32;
  localparam int CMPW  = (SQW > 2 * DZ_W) ? SQW : 2 * DZ_W;
  localparam int LW    = (RW > DZ_W + 8) ? RW : DZ_W + 8;
  localparam int CNT_W = $clog2(RW);

  stk_state_t state, state_next;

  logic signed [AW-1:0]   xs, ys;
  logic                   xneg, yneg;
  logic [AW-1:0]          mx, my;
  logic [SQW-1:0]         x2, y2;
  logic [2*DZ_W-1:0]      dz2;
  logic [RADW-1:0]        rad;
  logic [REMW-1:0]        rem;
  logic [RW-1:0]          root;
  logic [RW-1:0]          nlen;
  logic [FS_W-1:0]        dsel;
  logic [AW+RW-1:0]       px, py;
  logic [RW+FS_W-1:0]     den;
  logic [DW-1:0]          nx, ny, dsh;
  logic [QUO_W-1:0]       qx, qy;
  logic [CNT_W-1:0]       cnt;
  logic [AXIS_W-1:0]      xo, yo;

  logic [SQW-1:0]         sq;
  logic                   in_dead;
  logic [REMW-1:0]        rem_sh;
  logic [REMW-1:0]        trial;
  logic [LW-1:0]          root_w, dz8_w;
  logic [QUO_W-2:0]       qx_sat, qy_sat;

  assign rsp.busy  = (state != STK_IDLE);
  assign rsp.x_out = xo;
  assign rsp.y_out = yo;

  // Dead-zone test, one root digit and quotient saturation
  always_comb begin
    sq      = x2 + y2;
    in_dead = (CMPW'(sq) < CMPW'(dz2)) || (sq == '0);
    rem_sh  = {rem[REMW-3:0], rad[RADW-1 -: 2]};
    trial   = REMW'({root, 2'b01});
    root_w  = LW'(root);
    dz8_w   = LW'({dz, 8'b0});
    qx_sat  = qx[QUO_W-1] ? Q15_MAX : qx[QUO_W-2:0];
    qy_sat  = qy[QUO_W-1] ? Q15_MAX : qy[QUO_W-2:0];
  end

  // Sequence the lane
  always_comb begin
    state_next = state;
    unique case (state)
      STK_IDLE:   if (start) state_next = STK_SQUARE;
      STK_SQUARE: state_next = STK_CHECK;
      STK_CHECK:  state_next = in_dead ? STK_IDLE : STK_ROOT;
      STK_ROOT:   if (cnt == CNT_W'(RW - 1)) state_next = STK_PREP;
      STK_PREP:   state_next = STK_MUL;
      STK_MUL:    state_next = STK_NUM;
      STK_NUM:    state_next = STK_DIV;
      STK_DIV:    if (cnt == CNT_W'(QUO_W - 1)) state_next = STK_FIN;
      STK_FIN:    state_next = STK_IDLE;
      default:    state_next = STK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      STK_IDLE: begin
        xs <= x_raw[AW-1:0];
        ys <= y_raw[AW-1:0];
      end
      STK_SQUARE: begin
        x2   <= xs * xs;
        y2   <= ys * ys;
        dz2  <= dz * dz;
        xneg <= xs[AW-1];
        yneg <= ys[AW-1];
        mx   <= xs[AW-1] ? AW'(-xs) : AW'(xs);
        my   <= ys[AW-1] ? AW'(-ys) : AW'(ys);
      end
      STK_CHECK: begin
        rad  <= {sq, 16'b0};
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        if (in_dead) begin
          xo <= '0;
          yo <= '0;
        end
      end
      STK_ROOT: begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RW-2:0], 1'b0};
        end
        rad <= {rad[RADW-3:0], 2'b00};
        cnt <= cnt + 1'b1;
      end
      STK_PREP: begin
        nlen <= (root_w > dz8_w) ? RW'(root_w - dz8_w) : '0;
        dsel <= (fs > FS_W'(dz)) ? fs - FS_W'(dz) : FS_W'(1);
      end
      STK_MUL: begin
        px  <= mx * nlen;
        py  <= my * nlen;
        den <= root * dsel;
      end
      STK_NUM: begin
        nx  <= DW'({px, 15'b0}) - DW'(px) + DW'(den >> 1);
        ny  <= DW'({py, 15'b0}) - DW'(py) + DW'(den >> 1);
        dsh <= DW'({den, 15'b0});
        qx  <= '0;
        qy  <= '0;
        cnt <= '0;
      end
      STK_DIV: begin
        if (nx >= dsh) begin
          nx <= nx - dsh;
          qx <= {qx[QUO_W-2:0], 1'b1};
        end else begin
          qx <= {qx[QUO_W-2:0], 1'b0};
        end
        if (ny >= dsh) begin
          ny <= ny - dsh;
          qy <= {qy[QUO_W-2:0], 1'b1};
        end else begin
          qy <= {qy[QUO_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
      end
      STK_FIN: begin
        xo <= xneg ? AXIS_W'(-{1'b0, qx_sat}) : AXIS_W'({1'b0, qx_sat});
        yo <= yneg ? AXIS_W'(-{1'b0, qy_sat}) : AXIS_W'({1'b0, qy_sat});
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

@@ rtl/drz_back.sv @@
// Back end: takes queued commands, runs both stick lanes, keeps the held
// axes and drives the result register. Depends on drz_pkg, drz_stick, drz_out_if.
module drz_back #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  drz_pkg::drz_cmd_t         cmd,
  input  logic                      cmd_valid,
  output logic                      pop,
  input  logic [drz_pkg::DZ_W-1:0]  dz,
  input  logic [drz_pkg::FS_W-1:0]  fs,
  drz_out_if.source                 result
);
  import drz_pkg::*;

  bk_state_t         state, state_next;
  drz_lane_rsp_t     left_rsp, right_rsp;
  logic [AXIS_W-1:0] held [4];
  logic              slot_free;
  logic              lane_start;
  logic              load_hold;
  logic              load_new;

  drz_stick #(.AXIS_WIDTH(AXIS_WIDTH)) u_left (
    .clk(clk), .rst(rst), .start(lane_start),
    .x_raw(cmd.left_x), .y_raw(cmd.left_y), .dz(dz), .fs(fs), .rsp(left_rsp)
  );

  drz_stick #(.AXIS_WIDTH(AXIS_WIDTH)) u_right (
    .clk(clk), .rst(rst), .start(lane_start),
    .x_raw(cmd.right_x), .y_raw(cmd.right_y), .dz(dz), .fs(fs), .rsp(right_rsp)
  );

  assign slot_free = !result.valid || result.ready;

  // Dispatch commands and collect lane results
  always_comb begin
    state_next = state;
    lane_start = 1'b0;
    load_hold  = 1'b0;
    load_new   = 1'b0;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && cmd.hold) begin
          if (slot_free) begin
            load_hold = 1'b1;
            pop       = 1'b1;
          end
        end else if (cmd_valid) begin
          lane_start = 1'b1;
          pop        = 1'b1;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!left_rsp.busy && !right_rsp.busy && slot_free) begin
          load_new   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Hold state, held axes and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      result.valid <= 1'b0;
      held[0]      <= '0;
      held[1]      <= '0;
      held[2]      <= '0;
      held[3]      <= '0;
    end else begin
      state <= state_next;
      if (load_hold || load_new) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (load_new) begin
        held[0] <= left_rsp.x_out;
        held[1] <= left_rsp.y_out;
        held[2] <= right_rsp.x_out;
        held[3] <= right_rsp.y_out;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_new) begin
      result.left_x_out  <= left_rsp.x_out;
      result.left_y_out  <= left_rsp.y_out;
      result.right_x_out <= right_rsp.x_out;
      result.right_y_out <= right_rsp.y_out;
      result.updated     <= 1'b1;
    end else if (load_hold) begin
      result.left_x_out  <= held[0];
      result.left_y_out  <= held[1];
      result.right_x_out <= held[2];
      result.right_y_out <= held[3];
      result.updated     <= 1'b0;
    end
  end

  a_lane_busy: assert property (@(posedge clk) disable iff (rst)
    lane_start |=> (left_rsp.busy && right_rsp.busy))
    else $error("stick lanes did not start");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == BK_IDLE))
    else $error("command popped while lanes running");

  a_hold_value: assert property (@(posedge clk) disable iff (rst)
    load_hold |=> (result.valid && !result.updated && result.left_x_out == held[0]))
    else $error("held transaction lost held axes");

endmodule
